FILE: rtl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared codes and types of the text console scrollback engine: request
// modes, special character codes and the per-request control word.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam logic [2:0] MODE_PUT    = 3'd0;
  localparam logic [2:0] MODE_UP     = 3'd1;
  localparam logic [2:0] MODE_DOWN   = 3'd2;
  localparam logic [2:0] MODE_FOLLOW = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;
  localparam logic [2:0] MODE_READ   = 3'd5;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] COLOR_RESET  = 8'h0F;

  localparam logic [1:0] ADDR_TEXT_COLOR = 2'd0;

  typedef struct packed {
    logic        mem_we;
    logic        mem_re;
    logic        read_ok;
    logic        clear;
    logic        changed;
    logic [15:0] mem_wdata;
    logic        cell_write;
    logic [4:0]  write_row;
    logic [6:0]  write_col;
    logic [7:0]  write_char;
    logic [7:0]  write_color;
  } step_ctl_t;

endpackage

FILE: rtl/text_console_scrollback.sv
// ----------------------------------------------------------------------------
// text_console_scrollback
// Text console engine: cursor, view offset and a scrollback store of
// character/attribute cells held in one synchronous single-port memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ channel (valid/stall) and carry a mode, a
//   character, and a screen row/column for cell reads. Each request yields
//   exactly one result on the out_ channel: the visible cell written (if any),
//   cursor visibility and linear position, repaint flag, view offset and the
//   character/attribute of a read cell.
//   The attribute byte lives in one APB register (text_color, offset 0).
// Timing:
//   A request is decoded at its accept edge, touches the cell memory in the
//   memory state and is loaded into the output register from the output
//   state; in_stall stays high until that load, so the block takes no new
//   request before the last one has reached the output register.
//   Clear walks every cell, one per cycle, before its result goes out.
// Reset:
//   rst_n (synchronous) zeroes the cursor and view and then runs a clearing
//   pass over every cell with in_stall high.
// Backpressure:
//   While out_stall holds a result, one more request is still accepted and
//   waits in front of the output register until it is free.
// ----------------------------------------------------------------------------
module text_console_scrollback #(
  parameter int COLUMNS      = 80,
  parameter int SCREEN_ROWS  = 25,
  parameter int HISTORY_ROWS = 200
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_view_row,
  input  logic [6:0]  in_view_col,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_cell_write,
  output logic [4:0]  out_write_row,
  output logic [6:0]  out_write_col,
  output logic [7:0]  out_write_char,
  output logic [7:0]  out_write_color,
  output logic        out_cursor_visible,
  output logic [10:0] out_cursor_pos,
  output logic        out_view_changed,
  output logic [7:0]  out_view_offset,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_color,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW      = $clog2(HISTORY_ROWS);
  localparam int CW      = $clog2(COLUMNS + 1);
  localparam int DEPTH   = HISTORY_ROWS * COLUMNS;
  localparam int AW      = $clog2(DEPTH);
  localparam int EW      = $clog2(HISTORY_ROWS + SCREEN_ROWS + 32);
  localparam int PPW     = $clog2(SCREEN_ROWS * COLUMNS + 1);
  localparam int MAX_TOP = (HISTORY_ROWS > SCREEN_ROWS) ? HISTORY_ROWS - SCREEN_ROWS : 0;

  // sequencer states
  localparam logic [1:0] ST_WALK = 2'd0;  // sweep the store, one cell a cycle
  localparam logic [1:0] ST_IDLE = 2'd1;  // take a request
  localparam logic [1:0] ST_MEM  = 2'd2;  // cell write or read
  localparam logic [1:0] ST_OUT  = 2'd3;  // load the output register

  logic [1:0]          state_r, state_nxt;
  logic [LW-1:0]       cl_r, tl_r, step_line, step_top;
  logic [CW-1:0]       cc_r, step_col;
  logic [7:0]          color_r;
  tcs_pkg::step_ctl_t  ctl_r, step_ctl;
  logic [AW-1:0]       addr_r, step_addr;
  logic [AW-1:0]       walk_cnt_r;
  logic [15:0]         walk_data_r;
  logic                walk_emit_r;
  logic                walk_last;

  logic [15:0]         mem [DEPTH];
  logic [15:0]         rd_data_r;
  logic [AW-1:0]       mem_addr;
  logic [15:0]         mem_wdata;
  logic                mem_we;

  logic                vis_r, vis;
  logic [10:0]         pos_r;
  logic [EW-1:0]       line_e, top_e;
  logic [PPW-1:0]      pos_full;

  logic                in_acc, out_acc, out_load, cfg_wr;

  logic                out_valid_r;
  logic                out_cell_write_r, out_view_changed_r, out_cursor_visible_r;
  logic [4:0]          out_write_row_r;
  logic [6:0]          out_write_col_r;
  logic [7:0]          out_write_char_r, out_write_color_r, out_view_offset_r;
  logic [7:0]          out_read_char_r, out_read_color_r;
  logic [10:0]         out_cursor_pos_r;

  // --------------------------------------------------------------------------
  // Configuration: one attribute register, always ready.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr == tcs_pkg::ADDR_TEXT_COLOR) begin
      prdata = {24'd0, color_r};
    end
  end

  // --------------------------------------------------------------------------
  // Request decode, evaluated against the live cursor and view at the
  // accept edge.
  // --------------------------------------------------------------------------
  tcs_step #(
    .COLUMNS      (COLUMNS),
    .SCREEN_ROWS  (SCREEN_ROWS),
    .HISTORY_ROWS (HISTORY_ROWS)
  ) u_step (
    .mode       (in_mode),
    .char_code  (in_char_code),
    .view_row   (in_view_row),
    .view_col   (in_view_col),
    .text_color (color_r),
    .cur_line   (cl_r),
    .cur_col    (cc_r),
    .cur_top    (tl_r),
    .nxt_line   (step_line),
    .nxt_col    (step_col),
    .nxt_top    (step_top),
    .mem_addr   (step_addr),
    .ctl        (step_ctl)
  );

  // Only the idle state takes requests; a pending result does not block.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign walk_last = (walk_cnt_r == AW'(DEPTH - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_WALK: begin
        if (walk_last) begin
          state_nxt = walk_emit_r ? ST_MEM : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = step_ctl.clear ? ST_WALK : ST_MEM;
        end
      end
      ST_MEM: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WALK;
      cl_r        <= '0;
      cc_r        <= '0;
      tl_r        <= '0;
      color_r     <= tcs_pkg::COLOR_RESET;
      walk_cnt_r  <= '0;
      walk_data_r <= '0;
      walk_emit_r <= 1'b0;
      ctl_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        color_r <= pwdata[7:0];
      end
      if (in_acc) begin
        // commit cursor and view now; the memory stage only moves cells
        cl_r   <= step_line;
        cc_r   <= step_col;
        tl_r   <= step_top;
        ctl_r  <= step_ctl;
        addr_r <= step_addr;
        if (step_ctl.clear) begin
          walk_cnt_r  <= '0;
          walk_data_r <= {color_r, tcs_pkg::CH_SPACE};
          walk_emit_r <= 1'b1;
        end
      end
      if (state_r == ST_WALK) begin
        walk_cnt_r <= walk_last ? '0 : walk_cnt_r + AW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cell memory: single port, write during the sweep or the memory stage,
  // registered read in the memory stage.
  // --------------------------------------------------------------------------
  assign mem_addr  = (state_r == ST_WALK) ? walk_cnt_r : addr_r;
  assign mem_wdata = (state_r == ST_WALK) ? walk_data_r : ctl_r.mem_wdata;
  assign mem_we    = (state_r == ST_WALK) || ((state_r == ST_MEM) && ctl_r.mem_we);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if ((state_r == ST_MEM) && ctl_r.mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Cursor position on the screen, formed in the memory stage from the
  // committed cursor and view.
  // --------------------------------------------------------------------------
  assign line_e   = EW'(cl_r);
  assign top_e    = EW'(tl_r);
  assign vis      = (line_e >= top_e) && (line_e < top_e + EW'(SCREEN_ROWS));
  assign pos_full = PPW'(cl_r - tl_r) * PPW'(COLUMNS) + PPW'(cc_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_MEM) begin
      vis_r <= vis;
      pos_r <= vis ? 11'(pos_full) : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: load when free or being drained, hold while stalled.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cell_write_r     <= ctl_r.cell_write;
      out_write_row_r      <= ctl_r.write_row;
      out_write_col_r      <= ctl_r.write_col;
      out_write_char_r     <= ctl_r.write_char;
      out_write_color_r    <= ctl_r.write_color;
      out_cursor_visible_r <= vis_r;
      out_cursor_pos_r     <= pos_r;
      out_view_changed_r   <= ctl_r.changed;
      out_view_offset_r    <= 8'(tl_r);
      out_read_char_r      <= ctl_r.read_ok ? rd_data_r[7:0] : 8'd0;
      out_read_color_r     <= ctl_r.read_ok ? rd_data_r[15:8] : 8'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_write     = out_cell_write_r;
  assign out_write_row      = out_write_row_r;
  assign out_write_col      = out_write_col_r;
  assign out_write_char     = out_write_char_r;
  assign out_write_color    = out_write_color_r;
  assign out_cursor_visible = out_cursor_visible_r;
  assign out_cursor_pos     = out_cursor_pos_r;
  assign out_view_changed   = out_view_changed_r;
  assign out_view_offset    = out_view_offset_r;
  assign out_read_char      = out_read_char_r;
  assign out_read_color     = out_read_color_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_top_limit: assert property (@(posedge clk) disable iff (!rst_n)
    tl_r <= LW'(MAX_TOP))
    else $error("view offset beyond its limit");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cc_r < CW'(COLUMNS))
    else $error("cursor column beyond line end");

  a_one_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl_r.mem_we && ctl_r.mem_re))
    else $error("request both writes and reads the store");

  a_load_after_mem: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside the output state");

  a_walk_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |=> (state_r == ST_WALK) || (state_r == ST_MEM) ||
                             (state_r == ST_IDLE))
    else $error("sweep left to an unexpected state");

endmodule

FILE: rtl/tcs_step.sv
// ----------------------------------------------------------------------------
// tcs_step
// Decode of one console request: next cursor and view offset, the cell
// address to write or read, and the control word for the memory stage.
// ----------------------------------------------------------------------------
module tcs_step #(
  parameter int COLUMNS      = 80,
  parameter int SCREEN_ROWS  = 25,
  parameter int HISTORY_ROWS = 200
) (
  input  logic [2:0]                          mode,
  input  logic [7:0]                          char_code,
  input  logic [4:0]                          view_row,
  input  logic [6:0]                          view_col,
  input  logic [7:0]                          text_color,
  input  logic [$clog2(HISTORY_ROWS)-1:0]     cur_line,
  input  logic [$clog2(COLUMNS+1)-1:0]        cur_col,
  input  logic [$clog2(HISTORY_ROWS)-1:0]     cur_top,
  output logic [$clog2(HISTORY_ROWS)-1:0]     nxt_line,
  output logic [$clog2(COLUMNS+1)-1:0]        nxt_col,
  output logic [$clog2(HISTORY_ROWS)-1:0]     nxt_top,
  output logic [$clog2(HISTORY_ROWS*COLUMNS)-1:0] mem_addr,
  output tcs_pkg::step_ctl_t                  ctl
);

  localparam int LW      = $clog2(HISTORY_ROWS);
  localparam int CW      = $clog2(COLUMNS + 1);
  localparam int AW      = $clog2(HISTORY_ROWS * COLUMNS);
  localparam int EW      = $clog2(HISTORY_ROWS + SCREEN_ROWS + 32);
  localparam int MAX_TOP = (HISTORY_ROWS > SCREEN_ROWS) ? HISTORY_ROWS - SCREEN_ROWS : 0;

  logic [EW-1:0] line_e, top_e, top_lim_e, line_inc_e, cand_e, vrow_e;
  logic [LW-1:0] adv_line, bump_top, cand_line, mem_row;
  logic [CW-1:0] col_inc, mem_col;
  logic          on_scr, wrap, below, read_ok;
  logic [4:0]    scr_row;

  assign line_e     = EW'(cur_line);
  assign top_e      = EW'(cur_top);
  assign top_lim_e  = top_e + EW'(SCREEN_ROWS);
  assign line_inc_e = line_e + EW'(1);
  assign adv_line   = (line_inc_e < EW'(HISTORY_ROWS)) ? LW'(line_inc_e) : cur_line;
  assign bump_top   = (cur_top < LW'(MAX_TOP)) ? cur_top + LW'(1) : cur_top;
  assign on_scr     = (line_e >= top_e) && (line_e < top_lim_e);
  assign col_inc    = cur_col + CW'(1);
  assign wrap       = (col_inc >= CW'(COLUMNS));
  assign scr_row    = 5'(cur_line - cur_top);

  // Newline and a wrapping character move the cursor down one line.
  assign cand_line  = ((char_code == tcs_pkg::CH_NEWLINE) || wrap) ? adv_line : cur_line;
  assign cand_e     = EW'(cand_line);
  assign below      = (cand_e >= top_lim_e);

  assign vrow_e     = EW'(view_row) + top_e;
  assign read_ok    = (EW'(view_row) < EW'(SCREEN_ROWS)) && (9'(view_col) < 9'(COLUMNS)) &&
                      (vrow_e < EW'(HISTORY_ROWS));

  always_comb begin
    nxt_line = cur_line;
    nxt_col  = cur_col;
    nxt_top  = cur_top;
    mem_row  = cur_line;
    mem_col  = cur_col;
    ctl      = '0;
    case (mode)
      tcs_pkg::MODE_PUT: begin
        if (char_code == tcs_pkg::CH_NEWLINE) begin
          nxt_col     = '0;
          nxt_line    = cand_line;
          nxt_top     = below ? bump_top : cur_top;
          ctl.changed = below;
        end else if (char_code == tcs_pkg::CH_BACKSPACE) begin
          if (cur_col != '0) begin
            nxt_col       = cur_col - CW'(1);
            mem_col       = cur_col - CW'(1);
            ctl.mem_we    = 1'b1;
            ctl.mem_wdata = {text_color, tcs_pkg::CH_SPACE};
            if (on_scr) begin
              ctl.cell_write  = 1'b1;
              ctl.write_row   = scr_row;
              ctl.write_col   = 7'(cur_col - CW'(1));
              ctl.write_char  = tcs_pkg::CH_SPACE;
              ctl.write_color = text_color;
            end
          end
        end else begin
          ctl.mem_we    = 1'b1;
          ctl.mem_wdata = {text_color, char_code};
          if (on_scr) begin
            ctl.cell_write  = 1'b1;
            ctl.write_row   = scr_row;
            ctl.write_col   = 7'(cur_col);
            ctl.write_char  = char_code;
            ctl.write_color = text_color;
          end
          nxt_col     = wrap ? '0 : col_inc;
          nxt_line    = cand_line;
          nxt_top     = below ? bump_top : cur_top;
          ctl.changed = below;
        end
      end
      tcs_pkg::MODE_UP: begin
        nxt_top     = (cur_top != '0) ? cur_top - LW'(1) : cur_top;
        ctl.changed = 1'b1;
      end
      tcs_pkg::MODE_DOWN: begin
        nxt_top     = bump_top;
        ctl.changed = 1'b1;
      end
      tcs_pkg::MODE_FOLLOW: begin
        if (line_e < top_e) begin
          nxt_top = cur_line;
        end else if (line_e >= top_lim_e) begin
          nxt_top = LW'(line_e - EW'(SCREEN_ROWS) + EW'(1));
        end
        ctl.changed = 1'b1;
      end
      tcs_pkg::MODE_CLEAR: begin
        nxt_line    = '0;
        nxt_col     = '0;
        nxt_top     = '0;
        ctl.clear   = 1'b1;
        ctl.changed = 1'b1;
      end
      tcs_pkg::MODE_READ: begin
        mem_row     = LW'(vrow_e);
        mem_col     = CW'(view_col);
        ctl.mem_re  = read_ok;
        ctl.read_ok = read_ok;
      end
      default: begin
      end
    endcase
  end

  assign mem_addr = AW'(mem_row) * AW'(COLUMNS) + AW'(mem_col);

endmodule

FILE: verif/text_console_scrollback_tb.sv
// ----------------------------------------------------------------------------
// text_console_scrollback_tb
// Self-checking bench for the text console engine. A shadow copy of the
// scrollback store, cursor, view offset and attribute register computes the
// result of every accepted request. Each result on the out_ channel is
// compared field by field with the oldest pending one. Stimulus starts with
// a directed pass over the edge cases, then walks down the history and
// mixes random requests under several attribute settings. The sender runs in
// random bursts and the receiver stalls in shifting patterns.
// ----------------------------------------------------------------------------
module text_console_scrollback_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS      = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int HISTORY_ROWS = 200;
  localparam int MAX_TOP      = (HISTORY_ROWS > SCREEN_ROWS) ? HISTORY_ROWS - SCREEN_ROWS : 0;
  localparam int CELL_COUNT   = COLUMNS * HISTORY_ROWS;
  // Worst case: reset walk, a few dozen clear walks, ~1100 requests under
  // heavy stalls and sender gaps, taken several times over.
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] char_code;
    logic [4:0] view_row;
    logic [6:0] view_col;
  } console_req_t;

  typedef struct packed {
    logic        cell_write;
    logic [4:0]  write_row;
    logic [6:0]  write_col;
    logic [7:0]  write_char;
    logic [7:0]  write_color;
    logic        cursor_visible;
    logic [10:0] cursor_pos;
    logic        view_changed;
    logic [7:0]  view_offset;
    logic [7:0]  read_char;
    logic [7:0]  read_color;
  } console_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  // DUT inputs, all known from time zero.
  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [2:0]  in_mode      = tcs_pkg::MODE_PUT;
  logic [7:0]  in_char_code = '0;
  logic [4:0]  in_view_row  = '0;
  logic [6:0]  in_view_col  = '0;
  logic        out_stall    = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [1:0]  paddr        = tcs_pkg::ADDR_TEXT_COLOR;
  logic [31:0] pwdata       = '0;

  // DUT outputs.
  logic        in_stall;
  logic        out_valid;
  logic        out_cell_write;
  logic [4:0]  out_write_row;
  logic [6:0]  out_write_col;
  logic [7:0]  out_write_char;
  logic [7:0]  out_write_color;
  logic        out_cursor_visible;
  logic [10:0] out_cursor_pos;
  logic        out_view_changed;
  logic [7:0]  out_view_offset;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_color;
  logic [31:0] prdata;
  logic        pready;

  // Shadow console state.
  logic [15:0] scrollback [CELL_COUNT] = '{default: '0};
  logic [7:0]  cur_line = '0;
  logic [6:0]  cur_col  = '0;
  logic [7:0]  top_row  = '0;
  logic [7:0]  attr_reg = tcs_pkg::COLOR_RESET;

  // Console results still owed by the block, oldest first.
  console_result_t console_updates [$];

  int errors      = 0;
  int result_num  = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  bit valid_on    = 1'b0;

  text_console_scrollback #(
    .COLUMNS     (COLUMNS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .HISTORY_ROWS(HISTORY_ROWS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_char_code      (in_char_code),
    .in_view_row       (in_view_row),
    .in_view_col       (in_view_col),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_write    (out_cell_write),
    .out_write_row     (out_write_row),
    .out_write_col     (out_write_col),
    .out_write_char    (out_write_char),
    .out_write_color   (out_write_color),
    .out_cursor_visible(out_cursor_visible),
    .out_cursor_pos    (out_cursor_pos),
    .out_view_changed  (out_view_changed),
    .out_view_offset   (out_view_offset),
    .out_read_char     (out_read_char),
    .out_read_color    (out_read_color),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow console
  // --------------------------------------------------------------------------

  function automatic bit on_screen(input logic [7:0] line);
    return line >= top_row && int'(line) - int'(top_row) < SCREEN_ROWS;
  endfunction

  // Drop the cursor one line, holding it on the last history row.
  function automatic void next_line();
    if (int'(cur_line) + 1 < HISTORY_ROWS) cur_line = cur_line + 1'b1;
  endfunction

  // Advance the view one row when the cursor sits below the screen.
  function automatic logic push_view_down();
    if (cur_line >= top_row && int'(cur_line) - int'(top_row) >= SCREEN_ROWS) begin
      if (top_row < MAX_TOP) top_row = top_row + 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Write the cell under the cursor and flag it when it is on screen.
  function automatic void put_cell(input logic [7:0] ch, inout console_result_t res);
    scrollback[int'(cur_line) * COLUMNS + int'(cur_col)] = {attr_reg, ch};
    if (on_screen(cur_line)) begin
      res.cell_write  = 1'b1;
      res.write_row   = 5'(cur_line - top_row);
      res.write_col   = cur_col;
      res.write_char  = ch;
      res.write_color = attr_reg;
    end
  endfunction

  function automatic console_result_t console_advance(input console_req_t r);
    console_result_t res;
    int              line;
    int              pos;
    logic [15:0]     stored;
    res = '0;
    case (r.mode)
      tcs_pkg::MODE_PUT: begin
        if (r.char_code == tcs_pkg::CH_NEWLINE) begin
          cur_col = '0;
          next_line();
          res.view_changed = push_view_down();
        end else if (r.char_code == tcs_pkg::CH_BACKSPACE) begin
          // At column zero nothing is blanked and the cursor holds.
          if (cur_col != 0) begin
            cur_col = cur_col - 1'b1;
            put_cell(tcs_pkg::CH_SPACE, res);
          end
        end else begin
          put_cell(r.char_code, res);
          cur_col = cur_col + 1'b1;
          if (int'(cur_col) >= COLUMNS) begin
            cur_col = '0;
            next_line();
          end
          res.view_changed = push_view_down();
        end
      end
      tcs_pkg::MODE_UP: begin
        if (top_row > 0) top_row = top_row - 1'b1;
        res.view_changed = 1'b1;
      end
      tcs_pkg::MODE_DOWN: begin
        if (top_row < MAX_TOP) top_row = top_row + 1'b1;
        res.view_changed = 1'b1;
      end
      tcs_pkg::MODE_FOLLOW: begin
        if (cur_line < top_row) top_row = cur_line;
        if (int'(cur_line) >= int'(top_row) + SCREEN_ROWS)
          top_row = 8'(int'(cur_line) - SCREEN_ROWS + 1);
        res.view_changed = 1'b1;
      end
      tcs_pkg::MODE_CLEAR: begin
        foreach (scrollback[i]) scrollback[i] = {attr_reg, tcs_pkg::CH_SPACE};
        cur_line = '0;
        cur_col  = '0;
        top_row  = '0;
        res.view_changed = 1'b1;
      end
      tcs_pkg::MODE_READ: begin
        line = int'(r.view_row) + int'(top_row);
        if (r.view_row < SCREEN_ROWS && r.view_col < COLUMNS && line < HISTORY_ROWS) begin
          stored         = scrollback[line * COLUMNS + int'(r.view_col)];
          res.read_char  = stored[7:0];
          res.read_color = stored[15:8];
        end
      end
      default: ;  // unused modes leave everything alone
    endcase
    if (on_screen(cur_line)) begin
      pos = (int'(cur_line) - int'(top_row)) * COLUMNS + int'(cur_col);
      res.cursor_visible = 1'b1;
      res.cursor_pos     = 11'(pos);
    end
    res.view_offset = top_row;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] result %0d: %s", $realtime, result_num, msg);
  endtask

  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_cell_write, out_write_row, out_write_col, out_write_char, out_write_color,
              out_cursor_visible, out_cursor_pos, out_view_changed, out_view_offset,
              out_read_char, out_read_color};
      if (console_updates.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = console_updates.pop_front();
        if (got.cell_write !== want.cell_write)
          report_mismatch($sformatf("cell_write %0h, want %0h", got.cell_write, want.cell_write));
        if (got.write_row !== want.write_row)
          report_mismatch($sformatf("write_row %0d, want %0d", got.write_row, want.write_row));
        if (got.write_col !== want.write_col)
          report_mismatch($sformatf("write_col %0d, want %0d", got.write_col, want.write_col));
        if (got.write_char !== want.write_char)
          report_mismatch($sformatf("write_char %0h, want %0h", got.write_char, want.write_char));
        if (got.write_color !== want.write_color)
          report_mismatch($sformatf("write_color %0h, want %0h",
                                    got.write_color, want.write_color));
        if (got.cursor_visible !== want.cursor_visible)
          report_mismatch($sformatf("cursor_visible %0h, want %0h",
                                    got.cursor_visible, want.cursor_visible));
        if (got.cursor_pos !== want.cursor_pos)
          report_mismatch($sformatf("cursor_pos %0d, want %0d", got.cursor_pos, want.cursor_pos));
        if (got.view_changed !== want.view_changed)
          report_mismatch($sformatf("view_changed %0h, want %0h",
                                    got.view_changed, want.view_changed));
        if (got.view_offset !== want.view_offset)
          report_mismatch($sformatf("view_offset %0d, want %0d",
                                    got.view_offset, want.view_offset));
        if (got.read_char !== want.read_char)
          report_mismatch($sformatf("read_char %0h, want %0h", got.read_char, want.read_char));
        if (got.read_color !== want.read_color)
          report_mismatch($sformatf("read_color %0h, want %0h", got.read_color, want.read_color));
      end
      result_num++;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stalls: pick a new style after each random-length run so that
  // stalls land on every phase of the block's work.
  // --------------------------------------------------------------------------
  stall_style_t stall_style = STALL_NONE;
  int           stall_left  = 0;
  int           stall_tick  = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left  = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
      default:     out_stall <= (stall_tick % 7) < 3;
    endcase
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_console_scrollback_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Present one request and hold it until accepted; then keep valid up for
  // the rest of the burst or drop it for a random gap.
  task automatic send_request(input console_req_t r);
    int gap;
    in_valid     <= 1'b1;
    in_mode      <= r.mode;
    in_char_code <= r.char_code;
    in_view_row  <= r.view_row;
    in_view_col  <= r.view_col;
    valid_on = 1'b1;
    do @(posedge clk); while (in_stall);
    console_updates.push_back(console_advance(r));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_on = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_fields(input logic [2:0] mode, input logic [7:0] ch,
                             input logic [4:0] row, input logic [6:0] col);
    send_request('{mode, ch, row, col});
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic drain_results();
    if (valid_on) begin
      in_valid <= 1'b0;
      valid_on = 1'b0;
      @(posedge clk);
    end
    while (console_updates.size() != 0) @(posedge clk);
  endtask

  // Mostly characters, with the newline share set by the caller; the rest
  // scrolls, follows, reads (mostly on screen), rare clears and unused modes.
  function automatic console_req_t random_request(input int newline_pct, input bit allow_clear);
    console_req_t r;
    int           pick;
    int           sub;
    r.mode      = tcs_pkg::MODE_PUT;
    r.char_code = 8'($urandom_range(0, 255));
    r.view_row  = 5'($urandom_range(0, 31));
    r.view_col  = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      sub = $urandom_range(0, 99);
      if (sub < newline_pct) r.char_code = tcs_pkg::CH_NEWLINE;
      else if (sub < newline_pct + 8) r.char_code = tcs_pkg::CH_BACKSPACE;
    end else if (pick < 76) begin
      r.mode = tcs_pkg::MODE_UP;
    end else if (pick < 82) begin
      r.mode = tcs_pkg::MODE_DOWN;
    end else if (pick < 86) begin
      r.mode = tcs_pkg::MODE_FOLLOW;
    end else if (pick < 97 || (pick == 97 && !allow_clear)) begin
      r.mode = tcs_pkg::MODE_READ;
      if ($urandom_range(0, 4) != 0) begin
        r.view_row = 5'($urandom_range(0, SCREEN_ROWS - 1));
        r.view_col = 7'($urandom_range(0, COLUMNS - 1));
      end
    end else if (pick == 97) begin
      r.mode = tcs_pkg::MODE_CLEAR;
    end else begin
      r.mode = 3'($urandom_range(6, 7));
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------

  task automatic write_text_color(input logic [7:0] color);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tcs_pkg::ADDR_TEXT_COLOR;
    pwdata  <= {24'd0, color};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    attr_reg = color;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_text_color();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= tcs_pkg::ADDR_TEXT_COLOR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== attr_reg)
      report_mismatch($sformatf("text_color reads %0h, want %0h", prdata[7:0], attr_reg));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_reset_values();
    check_text_color();
  endtask

  task automatic test_directed();
    send_fields(tcs_pkg::MODE_READ, 8'h00, 5'd0, 7'd0);      // untouched store reads zero
    send_fields(tcs_pkg::MODE_PUT, 8'h41, 5'd0, 7'd0);
    send_fields(tcs_pkg::MODE_PUT, 8'h00, 5'd0, 7'd0);       // zero byte is printed
    send_fields(tcs_pkg::MODE_PUT, 8'hFF, 5'd0, 7'd0);
    send_fields(tcs_pkg::MODE_PUT, tcs_pkg::CH_BACKSPACE, 5'd0, 7'd0);  // blank the 0xFF cell
    send_fields(tcs_pkg::MODE_PUT, tcs_pkg::CH_NEWLINE, 5'd0, 7'd0);
    send_fields(tcs_pkg::MODE_PUT, tcs_pkg::CH_BACKSPACE, 5'd0, 7'd0);  // column zero: no write
    send_fields(tcs_pkg::MODE_UP, 8'h00, 5'd0, 7'd0);        // already at top, still repaint
    send_fields(tcs_pkg::MODE_DOWN, 8'h00, 5'd0, 7'd0);
    send_fields(tcs_pkg::MODE_DOWN, 8'h00, 5'd0, 7'd0);      // cursor now above the screen
    send_fields(tcs_pkg::MODE_PUT, 8'h42, 5'd0, 7'd0);       // hidden write, view holds
    send_fields(tcs_pkg::MODE_FOLLOW, 8'h00, 5'd0, 7'd0);
    send_fields(tcs_pkg::MODE_READ, 8'h00, 5'd0, 7'd0);
    send_fields(tcs_pkg::MODE_READ, 8'h00, 5'd31, 7'd0);     // row past the screen
    send_fields(tcs_pkg::MODE_READ, 8'h00, 5'd0, 7'd127);    // column past the line
    send_fields(tcs_pkg::MODE_READ, 8'h00, 5'd24, 7'd79);
    send_fields(tcs_pkg::MODE_READ, 8'hFF, 5'd25, 7'd80);
    send_fields(3'd6, 8'hFF, 5'd31, 7'd127);                 // unused modes
    send_fields(3'd7, 8'h00, 5'd0, 7'd0);
    send_fields(tcs_pkg::MODE_CLEAR, 8'h00, 5'd0, 7'd0);
    send_fields(tcs_pkg::MODE_READ, 8'h00, 5'd0, 7'd0);      // blank with current color
    drain_results();
  endtask

  // Newline-heavy stream with scrolls: push the cursor off the bottom of
  // the screen and carry the view down through the history.
  task automatic test_history_walk();
    repeat (320) send_request(random_request(70, 1'b0));
    drain_results();
  endtask

  // Mixed traffic under the attribute extremes, a random one and the reset
  // value again. Writes happen only with the block idle.
  task automatic test_text_color();
    logic [7:0] colors [4];
    colors = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), tcs_pkg::COLOR_RESET};
    foreach (colors[i]) begin
      drain_results();
      repeat (4) @(posedge clk);
      write_text_color(colors[i]);
      check_text_color();
      repeat (120) send_request(random_request(25, 1'b1));
    end
    drain_results();
  endtask

  // Mixed traffic with the sender holding off until the block has emptied.
  task automatic test_drain_pauses();
    for (int k = 0; k < 250; k++) begin
      send_request(random_request(30, 1'b1));
      if (k % 40 == 39) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Hold off until the post-reset clearing walk lets requests in.
    repeat (2) @(posedge clk);
    while (in_stall) @(posedge clk);
    test_reset_values();
    test_directed();
    test_history_walk();
    test_text_color();
    test_drain_pauses();
    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("text_console_scrollback_tb passed");
    end else begin
      $display("text_console_scrollback_tb failed");
    end
    $finish;
  end

endmodule
